// ----- hdl/swiglu_activation_top_macros.svh -----
// assertion macros for the swiglu activation block
`ifndef SWIGLU_ACTIVATION_TOP_MACROS_SVH
`define SWIGLU_ACTIVATION_TOP_MACROS_SVH
`ifndef SYNTH
`define SWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/swg_pkg.sv -----
// constants and helpers for the swiglu activation datapath
package swg_pkg;

    localparam int T_W      = 21;
    localparam int U_W      = 28;
    localparam int U_SHIFT  = U_W - T_W;
    localparam int U2_W     = 25;
    localparam int U3_W     = 22;
    localparam int U4_W     = 19;
    localparam int X_W      = 32;
    localparam int DEN_W    = 33;
    localparam int REM_W    = 32;
    localparam int S_W      = 32;
    localparam int N_SQUARE = 8;
    localparam int N_DIV    = S_W;

    localparam int D3_IN_W   = 21;
    localparam int D3_MULT_W = 19;
    localparam int D3_SHIFT  = 20;
    localparam int D3_P_W    = D3_IN_W + D3_MULT_W;
    localparam int D3_OUT_W  = D3_P_W - D3_SHIFT;
    localparam logic [D3_MULT_W-1:0] D3_MULT = 19'd349526;

    localparam logic [T_W-1:0] T_LIMIT   = 21'h10_0000;
    localparam logic [63:0]    T_LIMIT_W = 64'h10_0000;
    localparam logic [X_W-1:0] Q31_ONE   = 32'h8000_0000;
    localparam logic [63:0]    Q31_HALF  = 64'h4000_0000;
    localparam logic [63:0]    Q62_ONE   = 64'h4000_0000_0000_0000;

    // floor(a / 3) for a below 2^19, exact by reciprocal
    function automatic logic [D3_OUT_W-1:0] div3(input logic [D3_IN_W-1:0] a);
        logic [D3_P_W-1:0] p;
        p = D3_P_W'(a) * D3_P_W'(D3_MULT);
        return p[D3_P_W-1:D3_SHIFT];
    endfunction

endpackage

// ----- hdl/swiglu_activation_top.sv -----
// swiglu activation: result = gate * value * sigmoid(alpha * gate), signed fixed point
// throughput: one word per cycle; 52 register stages move together, frozen only
// while both the output register and the skid register hold words
// reset clears all valid bits, including the output and skid valids, and loads alpha with 1.0
`include "swiglu_activation_top_macros.svh"

module swiglu_activation_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic signed [DATA_WIDTH-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_gate,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_result,
    output logic                         m_saturated,
    output logic                         m_last_out
);

    localparam int P_W   = 2 * DATA_WIDTH;
    localparam int M_W   = 2 * DATA_WIDTH - 1;
    localparam int MH_W  = (M_W > 31) ? M_W - 31 : 1;
    localparam int MX_W  = 31 + MH_W;
    localparam int PH_W  = MH_W + swg_pkg::S_W;
    localparam int PL_W  = 31 + swg_pkg::S_W;
    localparam int Q_W   = MH_W + 33;
    localparam int R_W   = Q_W + 1;
    localparam int TSH   = 2 * FRAC_BITS - 16;
    localparam int UU_W  = 2 * swg_pkg::U_W;
    localparam int U23_W = swg_pkg::U2_W + swg_pkg::U_W;
    localparam int U34_W = swg_pkg::U3_W + swg_pkg::U_W;
    localparam int XS_W  = swg_pkg::X_W + 1;

    localparam int U_LINE  = 5;
    localparam int U2_LINE = 4;
    localparam int D6_LINE = 2;

    localparam int ST_DV0  = 8 + swg_pkg::N_SQUARE;
    localparam int ST_PP   = ST_DV0 + swg_pkg::N_DIV + 1;
    localparam int N_STAGE = ST_PP + 3;
    localparam int N_SIDE  = N_STAGE - 1;

    localparam logic signed [DATA_WIDTH-1:0] ALPHA_RESET = DATA_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_MAX = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [R_W-1:0] ROUND_F = R_W'(64'd1 << (FRAC_BITS - 1));

    typedef struct packed {
        logic [MX_W-1:0] mag;
        logic            neg;
        logic            zpos;
        logic            last;
    } side_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result;
        logic                  sat;
        logic                  last;
    } word_t;

    logic                         en;
    logic [N_STAGE-1:0]           valid_reg;
    logic [N_STAGE-1:0]           valid_next;
    logic signed [DATA_WIDTH-1:0] alpha_reg;
    logic signed [DATA_WIDTH-1:0] alpha_next;

    side_t side_reg [N_SIDE];
    side_t side_next;

    logic signed [P_W-1:0] z_reg, z_next;
    logic signed [P_W-1:0] p_reg, p_next;
    logic                  last_reg, last_next;
    logic [P_W-1:0]        zm_reg, zm_next;

    logic [63:0] zm_w;
    logic [63:0] tsel;

    logic [swg_pkg::U_W-1:0]      u_reg [U_LINE];
    logic [swg_pkg::U_W-1:0]      u_next;
    logic [swg_pkg::U2_W-1:0]     u2_reg [U2_LINE];
    logic [swg_pkg::U2_W-1:0]     u2_next;
    logic [swg_pkg::U3_W-1:0]     u3_reg, u3_next;
    logic [swg_pkg::U4_W-1:0]     u4_reg, u4_next;
    logic [swg_pkg::D3_OUT_W-1:0] d6_reg [D6_LINE];
    logic [swg_pkg::D3_OUT_W-1:0] d6_next;
    logic [swg_pkg::D3_OUT_W-1:0] d24_reg, d24_next;
    logic [swg_pkg::X_W-1:0]      x_reg, x_next;

    logic [swg_pkg::X_W-1:0]   sq_reg   [swg_pkg::N_SQUARE];
    logic [swg_pkg::X_W-1:0]   sq_next  [swg_pkg::N_SQUARE];
    logic [swg_pkg::REM_W-1:0] rem_reg  [swg_pkg::N_DIV+1];
    logic [swg_pkg::REM_W-1:0] rem_next [swg_pkg::N_DIV+1];
    logic [swg_pkg::S_W-1:0]   qn_reg   [swg_pkg::N_DIV+1];
    logic [swg_pkg::S_W-1:0]   qn_next  [swg_pkg::N_DIV+1];
    logic [swg_pkg::DEN_W-1:0] den_reg  [swg_pkg::N_DIV+1];
    logic [swg_pkg::DEN_W-1:0] den_next [swg_pkg::N_DIV+1];

    logic [PH_W-1:0] ph_reg, ph_next;
    logic [PL_W-1:0] pl_reg, pl_next;
    logic [Q_W-1:0]  q_reg, q_next;
    logic [R_W-1:0]  r_reg, r_next;

    word_t fin_word;
    word_t m_word_reg, m_word_next;
    word_t skid_word_reg, skid_word_next;
    logic  m_valid_reg, m_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    logic  m_take;

    // argument magnitude to Q.16, saturated at 16.0
    assign zm_w = 64'(zm_reg);
    generate
        if (TSH >= 0) begin : g_shr
            assign tsel = zm_w >> TSH;
        end else begin : g_shl
            assign tsel = (zm_w > (swg_pkg::T_LIMIT_W >> (-TSH))) ? swg_pkg::T_LIMIT_W
                                                                  : (zm_w << (-TSH));
        end
    endgenerate

    always_comb begin
        logic [P_W-1:0]              pm;
        logic [swg_pkg::T_W-1:0]     t;
        logic [UU_W-1:0]             uu;
        logic [U23_W-1:0]            uuu;
        logic [U34_W-1:0]            uuuu;
        logic [XS_W-1:0]             xs;
        logic [63:0]                 sqp;
        logic [swg_pkg::X_W-1:0]     e;
        logic [63:0]                 num;
        logic [swg_pkg::DEN_W-1:0]   shv;
        logic [MX_W-1:0]             mag;
        logic [63:0]                 plr;
        logic [R_W-1:0]              rs;

        // stage 0: two products
        z_next    = P_W'(alpha_reg) * P_W'(s_gate);
        p_next    = P_W'(s_gate) * P_W'(s_value);
        last_next = s_last;

        // stage 1: magnitudes and signs
        zm_next        = z_reg[P_W-1] ? $unsigned(-z_reg) : $unsigned(z_reg);
        pm             = p_reg[P_W-1] ? $unsigned(-p_reg) : $unsigned(p_reg);
        side_next.mag  = MX_W'(pm);
        side_next.neg  = p_reg[P_W-1];
        side_next.zpos = !z_reg[P_W-1];
        side_next.last = last_reg;

        // stage 2: u = t / 256 in Q0.31
        t      = (tsel > swg_pkg::T_LIMIT_W) ? swg_pkg::T_LIMIT : tsel[swg_pkg::T_W-1:0];
        u_next = {t, {swg_pkg::U_SHIFT{1'b0}}};

        // stages 3 to 6: power terms and their divisions
        uu       = UU_W'(u_reg[0]) * UU_W'(u_reg[0]);
        u2_next  = uu[UU_W-1:31];
        uuu      = U23_W'(u2_reg[0]) * U23_W'(u_reg[1]);
        u3_next  = uuu[U23_W-1:31];
        uuuu     = U34_W'(u3_reg) * U34_W'(u_reg[2]);
        u4_next  = uuuu[U34_W-1:31];
        d6_next  = swg_pkg::div3(swg_pkg::D3_IN_W'(u3_reg >> 1));
        d24_next = swg_pkg::div3(swg_pkg::D3_IN_W'(u4_reg >> 3));

        // stage 7: series sum
        xs = XS_W'(swg_pkg::Q31_ONE) - XS_W'(u_reg[U_LINE-1])
           + XS_W'(u2_reg[U2_LINE-1] >> 1) - XS_W'(d6_reg[D6_LINE-1])
           + XS_W'(d24_reg);
        x_next = xs[swg_pkg::X_W-1:0];

        // eight rounded squarings
        for (int k = 0; k < swg_pkg::N_SQUARE; k++) begin
            sqp = (k == 0) ? 64'(x_reg) * 64'(x_reg) + swg_pkg::Q31_HALF
                           : 64'(sq_reg[k-1]) * 64'(sq_reg[k-1]) + swg_pkg::Q31_HALF;
            sq_next[k] = sqp[62:31];
        end

        // divider setup: numerator with half the divisor added for rounding
        e           = sq_reg[swg_pkg::N_SQUARE-1];
        den_next[0] = swg_pkg::DEN_W'(e) + swg_pkg::DEN_W'(swg_pkg::Q31_ONE);
        num         = side_reg[ST_DV0-2].zpos ? swg_pkg::Q62_ONE : (64'(e) << 31);
        num         = num + 64'(den_next[0] >> 1);
        rem_next[0] = num[63:32];
        qn_next[0]  = num[31:0];

        // restoring division, one quotient bit per stage
        for (int k = 1; k <= swg_pkg::N_DIV; k++) begin
            shv         = {rem_reg[k-1], qn_reg[k-1][swg_pkg::S_W-1]};
            den_next[k] = den_reg[k-1];
            if (shv >= den_reg[k-1]) begin
                rem_next[k] = swg_pkg::REM_W'(shv - den_reg[k-1]);
                qn_next[k]  = {qn_reg[k-1][swg_pkg::S_W-2:0], 1'b1};
            end else begin
                rem_next[k] = shv[swg_pkg::REM_W-1:0];
                qn_next[k]  = {qn_reg[k-1][swg_pkg::S_W-2:0], 1'b0};
            end
        end

        // product with sigmoid, split in two partial products
        mag     = side_reg[ST_PP-2].mag;
        ph_next = PH_W'(mag[MX_W-1:31]) * PH_W'(qn_reg[swg_pkg::N_DIV]);
        pl_next = PL_W'(mag[30:0]) * PL_W'(qn_reg[swg_pkg::N_DIV]);

        plr    = 64'(pl_reg) + swg_pkg::Q31_HALF;
        q_next = Q_W'(ph_reg) + Q_W'(plr >> 31);

        rs     = R_W'(q_reg) + ROUND_F;
        r_next = rs >> FRAC_BITS;

        // saturation and sign
        fin_word.last   = side_reg[N_SIDE-1].last;
        fin_word.sat    = 1'b0;
        fin_word.result = '0;
        if (r_reg == '0) begin
            fin_word.result = '0;
        end else if (side_reg[N_SIDE-1].neg) begin
            if (r_reg > R_W'(NEG_MAX)) begin
                fin_word.result = NEG_MAX;
                fin_word.sat    = 1'b1;
            end else begin
                fin_word.result = '0 - r_reg[DATA_WIDTH-1:0];
            end
        end else begin
            if (r_reg > R_W'(POS_MAX)) begin
                fin_word.result = POS_MAX;
                fin_word.sat    = 1'b1;
            end else begin
                fin_word.result = r_reg[DATA_WIDTH-1:0];
            end
        end
    end

    // output register with skid word
    always_comb begin
        en              = !skid_valid_reg;
        m_take          = !m_valid_reg || m_ready;
        valid_next      = en ? {valid_reg[N_STAGE-2:0], s_valid} : valid_reg;
        alpha_next      = cfg_wr_en ? cfg_wr_data : alpha_reg;
        m_valid_next    = m_valid_reg;
        m_word_next     = m_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg) begin
            if (m_take) begin
                m_valid_next    = 1'b1;
                m_word_next     = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end else if (valid_reg[N_STAGE-1]) begin
            if (m_take) begin
                m_valid_next = 1'b1;
                m_word_next  = fin_word;
            end else begin
                skid_valid_next = 1'b1;
                skid_word_next  = fin_word;
            end
        end else if (m_take) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
            alpha_reg      <= ALPHA_RESET;
        end else begin
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
            alpha_reg      <= alpha_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg    <= m_word_next;
        skid_word_reg <= skid_word_next;
        if (en) begin
            z_reg     <= z_next;
            p_reg     <= p_next;
            last_reg  <= last_next;
            zm_reg    <= zm_next;
            u_reg[0]  <= u_next;
            u2_reg[0] <= u2_next;
            u3_reg    <= u3_next;
            u4_reg    <= u4_next;
            d6_reg[0] <= d6_next;
            d24_reg   <= d24_next;
            x_reg     <= x_next;
            ph_reg    <= ph_next;
            pl_reg    <= pl_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
            side_reg[0] <= side_next;
            for (int k = 1; k < N_SIDE; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 1; k < U_LINE; k++) begin
                u_reg[k] <= u_reg[k-1];
            end
            for (int k = 1; k < U2_LINE; k++) begin
                u2_reg[k] <= u2_reg[k-1];
            end
            for (int k = 1; k < D6_LINE; k++) begin
                d6_reg[k] <= d6_reg[k-1];
            end
            for (int k = 0; k < swg_pkg::N_SQUARE; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k <= swg_pkg::N_DIV; k++) begin
                rem_reg[k] <= rem_next[k];
                qn_reg[k]  <= qn_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign s_ready     = en;
    assign m_valid     = m_valid_reg;
    assign m_result    = m_word_reg.result;
    assign m_saturated = m_word_reg.sat;
    assign m_last_out  = m_word_reg.last;

    `SWG_ASSERT_IMP(a_skid_needs_out, aclk, aresetn, skid_valid_reg, m_valid_reg, "skid word held without output word")
    `SWG_ASSERT_NXT(a_fin_lands, aclk, aresetn, en && valid_reg[N_STAGE-1], m_valid_reg || skid_valid_reg, "finished word dropped")
    `SWG_ASSERT_NXT(a_skid_fill, aclk, aresetn, !skid_valid_reg && valid_reg[N_STAGE-1] && m_valid_reg && !m_ready, skid_valid_reg, "stalled word not parked")
    `SWG_ASSERT_IMP(a_sat_extreme, aclk, aresetn, m_valid_reg && m_word_reg.sat, m_word_reg.result == POS_MAX || m_word_reg.result == NEG_MAX, "saturated word not at a limit")

endmodule

// ----- tb/sv/swiglu_activation_top_test.sv -----
// testbench for the swiglu activation block: bit-exact prediction against a streamed word checker
`timescale 1ns / 100ps

module swiglu_activation_top_test;

    localparam int DATA_WIDTH   = 16;
    localparam int FRAC_BITS    = 12;
    localparam int LATENCY      = 52;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_CAP   = 50;

    localparam logic [63:0] Q31_ONE  = 64'h8000_0000;
    localparam logic [63:0] T_CLAMP  = 64'd16 << 16;
    localparam logic [63:0] POS_MAX  = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] NEG_MAX  = 64'd1 << (DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] ALPHA_ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic                         saturated;
        logic                         last_out;
    } act_word_t;

    logic                         aclk;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic signed [DATA_WIDTH-1:0] cfg_wr_data = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic signed [DATA_WIDTH-1:0] s_gate      = '0;
    logic signed [DATA_WIDTH-1:0] s_value     = '0;
    logic                         s_last      = 1'b0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic signed [DATA_WIDTH-1:0] m_result;
    logic                         m_saturated;
    logic                         m_last_out;

    act_word_t                    activations_due[$];
    logic signed [DATA_WIDTH-1:0] alpha_model = ALPHA_ONE;
    int                           src_idle_pct = 7;
    int                           dst_idle_pct = 85;
    int                           mismatches = 0;
    int                           words_sent = 0;
    int                           words_checked = 0;
    int                           saturated_seen = 0;
    int                           alpha_loads = 0;
    int                           tensors_sent = 0;

    swiglu_activation_top #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_gate     (s_gate),
        .s_value    (s_value),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result),
        .m_saturated(m_saturated),
        .m_last_out (m_last_out)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // exp(-t) in q0.31 for t in q.16, t no more than 16.0
    function automatic logic [63:0] exp_neg_q31(input logic [63:0] t);
        logic [63:0] u, u2, u3, u4, x;
        int          i;
        u  = t << 7;
        u2 = (u * u) >> 31;
        u3 = (u2 * u) >> 31;
        u4 = (u3 * u) >> 31;
        x  = Q31_ONE - u + u2 / 2 - u3 / 6 + u4 / 24;
        for (i = 0; i < 8; i++) begin
            x = (x * x + (Q31_ONE >> 1)) >> 31;
        end
        return x;
    endfunction

    function automatic act_word_t swiglu_of(input logic signed [DATA_WIDTH-1:0] alpha,
                                            input logic signed [DATA_WIDTH-1:0] gate_w,
                                            input logic signed [DATA_WIDTH-1:0] value_w,
                                            input logic last_w);
        longint      z, gv;
        logic [63:0] zm, t, e, den, s, m, q, r;
        logic        neg;
        act_word_t   w;
        z  = longint'(alpha) * longint'(gate_w);
        zm = (z < 0) ? -z : z;
        t  = zm >> (2 * FRAC_BITS - 16);
        if (t > T_CLAMP) begin
            t = T_CLAMP;
        end
        e   = exp_neg_q31(t);
        den = Q31_ONE + e;
        if (z >= 0) begin
            s = ((Q31_ONE << 31) + den / 2) / den;
        end else begin
            s = ((e << 31) + den / 2) / den;
        end
        gv  = longint'(gate_w) * longint'(value_w);
        m   = (gv < 0) ? -gv : gv;
        neg = (gate_w < 0) != (value_w < 0);
        q   = (m * s + (Q31_ONE >> 1)) >> 31;
        r   = (q + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        w.saturated = 1'b0;
        w.last_out  = last_w;
        if (r == 0) begin
            w.result = '0;
        end else if (neg) begin
            if (r > NEG_MAX) begin
                r = NEG_MAX;
                w.saturated = 1'b1;
            end
            w.result = DATA_WIDTH'(-r);
        end else begin
            if (r > POS_MAX) begin
                r = POS_MAX;
                w.saturated = 1'b1;
            end
            w.result = DATA_WIDTH'(r);
        end
        return w;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        logic [DATA_WIDTH-1:0] w;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: w = 16'h7fff;
                    1: w = 16'h8000;
                    2: w = 16'h0000;
                    default: w = 16'hffff;
                endcase
            end
            1, 2: begin
                w = DATA_WIDTH'($urandom_range(0, 8191));
                if ($urandom_range(1)) begin
                    w = -w;
                end
            end
            default: w = DATA_WIDTH'($urandom);
        endcase
        return w;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_alpha();
        logic [DATA_WIDTH-1:0] w;
        case ($urandom_range(7))
            0: w = 16'h7fff;
            1: w = 16'h8000;
            2: w = 16'h0000;
            3, 4: begin
                w = DATA_WIDTH'($urandom_range(0, 16384));
                if ($urandom_range(1)) begin
                    w = -w;
                end
            end
            default: w = DATA_WIDTH'($urandom);
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [DATA_WIDTH-1:0] gate_w,
                             input logic [DATA_WIDTH-1:0] value_w,
                             input logic last_w);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_gate  <= gate_w;
        s_value <= value_w;
        s_last  <= last_w;
        do @(posedge aclk); while (!s_ready);
        activations_due.push_back(swiglu_of(alpha_model, gate_w, value_w, last_w));
        words_sent++;
    endtask

    task automatic wait_results_done();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (activations_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic load_alpha(input logic [DATA_WIDTH-1:0] alpha);
        wait_results_done();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= alpha;
        alpha_model  = alpha;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        alpha_loads++;
    endtask

    task automatic test_reset_alpha();
        send_word(16'h0000, 16'h0000, 1'b0);
        send_word(16'h7fff, 16'h7fff, 1'b0);
        send_word(16'h8000, 16'h8000, 1'b0);
        send_word(16'h7fff, 16'h8000, 1'b0);
        send_word(16'h8000, 16'h7fff, 1'b1);
        send_word(16'h1000, 16'h1000, 1'b0);
        send_word(16'hf000, 16'h1000, 1'b0);
        send_word(16'h0001, 16'h0001, 1'b0);
        send_word(16'hffff, 16'hffff, 1'b1);
        send_word(16'h0000, 16'h7fff, 1'b0);
    endtask

    task automatic test_alpha_extremes();
        logic [DATA_WIDTH-1:0] slopes[3];
        int                    k;
        slopes = '{16'h7fff, 16'h8000, 16'h0000};
        for (k = 0; k < 3; k++) begin
            load_alpha(slopes[k]);
            send_word(16'h7fff, 16'h7fff, 1'b0);
            send_word(16'h8000, 16'h1000, 1'b0);
            send_word(16'h0100, 16'hffff, 1'b0);
            send_word(16'h4000, 16'hc000, 1'b0);
            send_word(16'h0000, 16'h8000, 1'b1);
        end
    endtask

    task automatic test_random_tensors(input int n_words, input int src_pct, input int dst_pct);
        int   sent;
        int   len;
        int   k;
        logic lst;
        logic paused;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        sent   = 0;
        paused = 1'b0;
        load_alpha(pick_alpha());
        while (sent < n_words) begin
            if ($urandom_range(3) == 0) begin
                load_alpha(pick_alpha());
            end
            len = $urandom_range(1, 48);
            for (k = 0; k < len; k++) begin
                lst = (k == len - 1);
                // a stray or missing marker now and then
                if ($urandom_range(19) == 0) begin
                    lst = ~lst;
                end
                send_word(pick_operand(), pick_operand(), lst);
            end
            sent += len;
            tensors_sent++;
            if (!paused && sent >= n_words / 2) begin
                wait_results_done();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_words
        act_word_t want;
        act_word_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_result, m_saturated, m_last_out};
            if (activations_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP) begin
                    $display("%0t unexpected word: expected none, actual result %0d sat %0b last %0b",
                             $time, $signed(got.result), got.saturated, got.last_out);
                end else if (mismatches == REPORT_CAP + 1) begin
                    $display("%0t further mismatches not shown", $time);
                end
            end else begin
                want = activations_due.pop_front();
                words_checked++;
                if (want.saturated) begin
                    saturated_seen++;
                end
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP) begin
                        $display("%0t mismatch: expected result %0d sat %0b last %0b,",
                                 $time, $signed(want.result), want.saturated,
                                 want.last_out);
                        $display("    actual result %0d sat %0b last %0b",
                                 $signed(got.result), got.saturated, got.last_out);
                    end else if (mismatches == REPORT_CAP + 1) begin
                        $display("%0t further mismatches not shown", $time);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_alpha();
        test_alpha_extremes();
        test_random_tensors(530, 7, 85);
        test_random_tensors(530, 85, 7);
        test_random_tensors(530, 0, 0);
        wait_results_done();
        repeat (LATENCY + 8) @(posedge aclk);
        $display("sent %0d words in %0d random tensors, checked %0d results, %0d saturated",
                 words_sent, tensors_sent, words_checked, saturated_seen);
        $display("alpha loaded %0d times incl. both extremes and zero, %0d mismatches",
                 alpha_loads, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
